// File: rtl/core/stpr_pkg.sv
// Shared types and constants for the trapezoidal step-clock generator.
// Used by the controller, the datapath and the top level; no dependencies.
package stpr_pkg;

  localparam int STEP_FIELD_W = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_CMD  = 2'd2;

  localparam logic [7:0] CMD_FWD  = 8'h46;
  localparam logic [7:0] CMD_BWD  = 8'h42;
  localparam logic [7:0] CMD_STOP = 8'h53;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOWEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FASTEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_CW  = 2'd3;

  localparam logic [CFG_W-1:0] SLOWEST_RST = 16'd4000;
  localparam logic [CFG_W-1:0] FASTEST_RST = 16'd500;
  localparam logic [CFG_W-1:0] RAMP_RST    = 16'd10;
  localparam logic             FWD_CW_RST  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } stpr_state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic mul;
    logic eval;
    logic out_load;
  } stpr_cmd_t;

  typedef struct packed {
    logic step_due;
    logic out_free;
  } stpr_status_t;

endpackage

// File: rtl/core/stepper_trapezoid_ramp.sv
// Step-clock generator with a trapezoidal speed ramp for a stepper driver.
// Input words are timer ticks, add-steps requests or command bytes ('F', 'B',
// 'S'); every input word yields exactly one output word reporting the clock
// level, direction level, running flag, step flag, period and steps left.
// The input channel is taken when in_valid is high and in_stall is low; the
// output channel hands over a word when out_valid is high and out_stall is low.
// Configuration is written through cfg_write_en, cfg_index and cfg_wdata; the
// user must write it only while the block is idle; the block itself has no check for this.
// An ordinary word passes through the EXEC and DONE states to out_valid; a tick
// that completes a step also passes through MUL and EVAL, the braking-distance
// multiplier and the ramp evaluation. One word is worked on at a time, so the
// next word is accepted only after the sequencer has returned to IDLE.
// The output register lets the next word be accepted while a result waits; if
// the receiver keeps stalling, the block holds its next result and stalls its
// input in turn.
// Reset (synchronous, active low) restores the register defaults, stops the
// motor, clears the step count and sets the direction level high.
module stepper_trapezoid_ramp
  import stpr_pkg::*;
#(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic [STEP_FIELD_W-1:0] in_step_count,
  input  logic [7:0]              in_command_byte,
  input  logic                    cfg_write_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_motor_clock,
  output logic                    out_direction_level,
  output logic                    out_is_running,
  output logic                    out_step_taken,
  output logic [PERIOD_BITS-1:0]  out_current_period,
  output logic [COUNT_BITS-1:0]   out_steps_left
);

  stpr_cmd_t    cmd;
  stpr_status_t status;

  stpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  stpr_dp #(
    .PERIOD_BITS (PERIOD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_req_type         (in_req_type),
    .in_step_count       (in_step_count),
    .in_command_byte     (in_command_byte),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_motor_clock     (out_motor_clock),
    .out_direction_level (out_direction_level),
    .out_is_running      (out_is_running),
    .out_step_taken      (out_step_taken),
    .out_current_period  (out_current_period),
    .out_steps_left      (out_steps_left)
  );

endmodule

// File: rtl/core/stpr_ctrl.sv
// Sequencing state machine for the step-clock generator.
// Depends on stpr_pkg; drives the datapath through stpr_cmd_t.
module stpr_ctrl
  import stpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  stpr_status_t status,
  output stpr_cmd_t    cmd
);

  stpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = status.step_due ? ST_MUL : ST_DONE;
      end
      ST_MUL:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_EVAL: cmd.eval = 1'b1;
      ST_DONE: cmd.out_load = status.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// File: rtl/core/stpr_dp.sv
// Datapath of the step-clock generator: configuration, motion state,
// braking-distance multiply and the output word register. Depends on stpr_pkg.
module stpr_dp
  import stpr_pkg::*;
#(
  parameter int PERIOD_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stpr_cmd_t               cmd,
  output stpr_status_t            status,
  input  logic [1:0]              in_req_type,
  input  logic [STEP_FIELD_W-1:0] in_step_count,
  input  logic [7:0]              in_command_byte,
  input  logic                    cfg_write_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_motor_clock,
  output logic                    out_direction_level,
  output logic                    out_is_running,
  output logic                    out_step_taken,
  output logic [PERIOD_BITS-1:0]  out_current_period,
  output logic [COUNT_BITS-1:0]   out_steps_left
);

  localparam int PROD_W = COUNT_BITS + PERIOD_BITS;

  // Configuration registers.
  logic [CFG_W-1:0] slowest_r, fastest_r, ramp_r;
  logic             fwd_cw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slowest_r <= SLOWEST_RST;
      fastest_r <= FASTEST_RST;
      ramp_r    <= RAMP_RST;
      fwd_cw_r  <= FWD_CW_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_SLOWEST: slowest_r <= cfg_wdata;
        CFG_FASTEST: fastest_r <= cfg_wdata;
        CFG_RAMP:    ramp_r    <= cfg_wdata;
        CFG_FWD_CW:  fwd_cw_r  <= cfg_wdata[0];
        default:     slowest_r <= slowest_r;
      endcase
    end
  end

  // Register values brought to the period width (zero-extend or truncate).
  logic [PERIOD_BITS+CFG_W-1:0] slow_ext, fast_ext, ramp_ext, slow_rst_ext;
  logic [PERIOD_BITS-1:0]       slow, fast, inc_raw, inc, slow_rst;

  assign slow_ext     = {{PERIOD_BITS{1'b0}}, slowest_r};
  assign fast_ext     = {{PERIOD_BITS{1'b0}}, fastest_r};
  assign ramp_ext     = {{PERIOD_BITS{1'b0}}, ramp_r};
  assign slow_rst_ext = {{PERIOD_BITS{1'b0}}, SLOWEST_RST};
  assign slow         = slow_ext[PERIOD_BITS-1:0];
  assign fast         = fast_ext[PERIOD_BITS-1:0];
  assign inc_raw      = ramp_ext[PERIOD_BITS-1:0];
  assign slow_rst     = slow_rst_ext[PERIOD_BITS-1:0];
  assign inc          = (inc_raw == '0) ? PERIOD_BITS'(1) : inc_raw;

  // Captured input word.
  logic [1:0]            req_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [7:0]            cmdb_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_r   <= in_req_type;
      count_r <= in_step_count[COUNT_BITS-1:0];
      cmdb_r  <= in_command_byte;
    end
  end

  // Motion state.
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic [COUNT_BITS-1:0]  remain_r, remain_nxt;
  logic [PERIOD_BITS-1:0] tick_r, tick_nxt;
  logic half_r, half_nxt, clk_lvl_r, clk_lvl_nxt, dir_r, dir_nxt;
  logic run_r, run_nxt, stop_r, stop_nxt, rev_r, rev_nxt;
  logic stepped_r, stepped_nxt;
  logic [PROD_W-1:0]      prod_r;
  logic [PERIOD_BITS-1:0] diff_r;

  logic [PERIOD_BITS-1:0] tick_inc;
  logic                   tick_fire;
  logic [COUNT_BITS:0]    add_sum;
  logic [PERIOD_BITS:0]   up_sum;
  logic [PERIOD_BITS-1:0] period_up, period_down;
  logic                   brake_near;

  assign tick_inc   = (tick_r != '1) ? tick_r + PERIOD_BITS'(1) : tick_r;
  assign tick_fire  = run_r && (req_r == REQ_TICK) && (tick_inc >= period_r);
  assign add_sum    = {1'b0, remain_r} + {1'b0, count_r};
  assign up_sum     = {1'b0, period_r} + {1'b0, inc};
  assign period_up  = up_sum[PERIOD_BITS] ? '1 : up_sum[PERIOD_BITS-1:0];
  assign period_down = (period_r > inc) ? period_r - inc : '0;
  // remaining <= (slow - period) / inc, rewritten as remaining * inc <= slow - period.
  assign brake_near = (period_r < slow) && (prod_r <= {{COUNT_BITS{1'b0}}, diff_r});

  assign status.step_due = tick_fire && half_r;

  always_comb begin
    period_nxt  = period_r;
    remain_nxt  = remain_r;
    tick_nxt    = tick_r;
    half_nxt    = half_r;
    clk_lvl_nxt = clk_lvl_r;
    dir_nxt     = dir_r;
    run_nxt     = run_r;
    stop_nxt    = stop_r;
    rev_nxt     = rev_r;
    stepped_nxt = stepped_r;

    if (cmd.exec) begin
      stepped_nxt = 1'b0;
      case (req_r)
        REQ_TICK: begin
          if (run_r) begin
            if (tick_fire) begin
              tick_nxt    = '0;
              clk_lvl_nxt = ~clk_lvl_r;
              half_nxt    = ~half_r;
              stepped_nxt = half_r;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        REQ_ADD: begin
          remain_nxt = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
          if (!run_r && (remain_nxt != '0)) run_nxt = 1'b1;
        end
        REQ_CMD: begin
          case (cmdb_r)
            CMD_FWD:  if (dir_r != fwd_cw_r) rev_nxt = 1'b1;
            CMD_BWD:  if (dir_r == fwd_cw_r) rev_nxt = 1'b1;
            CMD_STOP: begin
              stop_nxt   = 1'b1;
              remain_nxt = '0;
            end
            default: rev_nxt = rev_r;
          endcase
        end
        default: run_nxt = run_r;
      endcase
    end

    if (cmd.eval) begin
      if (rev_r) begin
        if (period_r < slow) begin
          period_nxt = period_up;
        end else begin
          period_nxt = slow;
          dir_nxt    = ~dir_r;
          rev_nxt    = 1'b0;
        end
      end else if (stop_r) begin
        if (period_r < slow) begin
          period_nxt = period_up;
        end else begin
          run_nxt    = 1'b0;
          stop_nxt   = 1'b0;
          period_nxt = slow;
        end
      end else if (remain_r == '0) begin
        run_nxt    = 1'b0;
        stop_nxt   = 1'b0;
        period_nxt = slow;
      end else if (brake_near) begin
        period_nxt = period_up;
      end else if (period_r > fast) begin
        period_nxt = period_down;
      end
      if (remain_r != '0) remain_nxt = remain_r - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= slow_rst;
      remain_r  <= '0;
      tick_r    <= '0;
      half_r    <= 1'b0;
      clk_lvl_r <= 1'b0;
      dir_r     <= FWD_CW_RST;
      run_r     <= 1'b0;
      stop_r    <= 1'b0;
      rev_r     <= 1'b0;
      stepped_r <= 1'b0;
    end else begin
      period_r  <= period_nxt;
      remain_r  <= remain_nxt;
      tick_r    <= tick_nxt;
      half_r    <= half_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      dir_r     <= dir_nxt;
      run_r     <= run_nxt;
      stop_r    <= stop_nxt;
      rev_r     <= rev_nxt;
      stepped_r <= stepped_nxt;
    end
  end

  // Braking-distance product, registered ahead of the compare.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(remain_r) * PROD_W'(inc);
      diff_r <= slow - period_r;
    end
  end

  // Output word register; a new word may be prepared while this one waits.
  logic out_valid_r;

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_motor_clock     <= clk_lvl_r;
      out_direction_level <= dir_r;
      out_is_running      <= run_r;
      out_step_taken      <= stepped_r;
      out_current_period  <= period_r;
      out_steps_left      <= remain_r;
    end
  end

endmodule
